// ===== rtl/core/lpm_pkg.sv =====
// Shared types, sizes and helpers for the IPv4 longest prefix match engine.
package lpm_pkg;

  localparam int TABLE_ENTRIES = 32;
  localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int ADDR_W        = 32;
  localparam int PORT_W        = 4;
  localparam int LEN_W         = 6;
  localparam int INDEX_W       = 5;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
    logic [LEN_W-1:0]  plen;
  } route_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic             valid;
  } tbl_wr_t;

  function automatic logic [LEN_W-1:0] ones_in(input logic [ADDR_W-1:0] v);
    logic [LEN_W-1:0] n;
    n = '0;
    for (int i = 0; i < ADDR_W; i++) begin
      n = n + LEN_W'(v[i]);
    end
    return n;
  endfunction

endpackage

// ===== rtl/core/lpm_table.sv =====
// Route table: entry memory with registered read, plus per-slot valid flops.
module lpm_table
  import lpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  tbl_wr_t          wr_ctl,
  input  route_t           wr_route,
  input  logic [IDX_W-1:0] rd_idx,
  output route_t           rd_route,
  output logic             rd_valid
);

  route_t                   mem [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] valid_bits;

  always_ff @(posedge clk) begin
    if (wr_ctl.en) begin
      mem[wr_ctl.idx] <= wr_route;
    end
    rd_route <= mem[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (wr_ctl.en) begin
        valid_bits[wr_ctl.idx] <= wr_ctl.valid;
      end
      rd_valid <= valid_bits[rd_idx];
    end
  end

endmodule

// ===== rtl/core/ipv4_longest_prefix_match.sv =====
// IPv4 longest prefix match engine: sequencer, compare unit and result register.
// Lookup: scan, drain and finish states run from accept to result valid, one table slot
// compared per cycle through the single read port of the route memory.
// Write: accept, then memory write; no result beat.
// One beat at a time: a new request is taken only once the last one is through, and a lookup
// waits longer in its finish state while an earlier result beat waits for rsp_ready.
// Reset (rst, synchronous): all route slots invalid, no result pending.
module ipv4_longest_prefix_match
  import lpm_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               operation,
  input  logic [INDEX_W-1:0] entry_index,
  input  logic               entry_valid,
  input  logic [ADDR_W-1:0]  entry_dest,
  input  logic [ADDR_W-1:0]  entry_mask,
  input  logic [ADDR_W-1:0]  entry_gateway,
  input  logic [PORT_W-1:0]  entry_port,
  input  logic [ADDR_W-1:0]  lookup_address,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  output logic               found,
  output logic [ADDR_W-1:0]  next_hop,
  output logic [PORT_W-1:0]  out_port,
  output logic [LEN_W-1:0]   prefix_length
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_WRITE  = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  state_t            state, state_next;
  logic              accept;
  logic              idx_ok;

  // captured beat
  logic [ADDR_W-1:0] addr;
  route_t            wr_route;
  logic [IDX_W-1:0]  wr_idx;
  logic              wr_vld;
  logic              wr_ok;

  logic [IDX_W-1:0]  idx;
  logic              cmp_en;
  tbl_wr_t           wr_ctl;
  route_t            rd_route;
  logic              rd_valid;

  logic              best_hit;
  logic [LEN_W-1:0]  best_len;
  logic [ADDR_W-1:0] best_gw;
  logic [PORT_W-1:0] best_port;
  logic              hit;
  logic              take;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign idx_ok    = (32'(entry_index) < 32'(TABLE_ENTRIES));

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (operation == OP_LOOKUP) ? ST_SCAN : ST_WRITE;
        end
      end
      ST_WRITE:  state_next = ST_IDLE;
      ST_SCAN: begin
        if (idx == IDX_W'(TABLE_ENTRIES - 1)) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN:  state_next = ST_FINISH;
      ST_FINISH: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cmp_en    <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state  <= state_next;
      cmp_en <= (state == ST_SCAN);
      if (state == ST_FINISH && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // beat capture; prefix length is worked out once here so the scan only compares
  always_ff @(posedge clk) begin
    if (accept) begin
      addr             <= lookup_address;
      wr_route.dest    <= entry_dest;
      wr_route.mask    <= entry_mask;
      wr_route.gateway <= entry_gateway;
      wr_route.port    <= entry_port;
      wr_route.plen    <= ones_in(entry_mask);
      wr_idx           <= IDX_W'(entry_index);
      wr_vld           <= entry_valid;
      wr_ok            <= idx_ok;
    end
  end

  assign wr_ctl.en    = (state == ST_WRITE) && wr_ok;
  assign wr_ctl.idx   = wr_idx;
  assign wr_ctl.valid = wr_vld;

  always_ff @(posedge clk) begin
    if (state == ST_SCAN) begin
      idx <= idx + 1'b1;
    end else begin
      idx <= '0;
    end
  end

  lpm_table u_table (
    .clk      (clk),
    .rst      (rst),
    .wr_ctl   (wr_ctl),
    .wr_route (wr_route),
    .rd_idx   (idx),
    .rd_route (rd_route),
    .rd_valid (rd_valid)
  );

  // compare unit: one slot per cycle, strict greater keeps the lowest index on a tie
  assign hit  = cmp_en && rd_valid
                && (((addr ^ rd_route.dest) & rd_route.mask) == '0);
  assign take = hit && (!best_hit || (rd_route.plen > best_len));

  always_ff @(posedge clk) begin
    if (state == ST_IDLE) begin
      best_hit  <= 1'b0;
      best_len  <= '0;
      best_gw   <= '0;
      best_port <= '0;
    end else if (take) begin
      best_hit  <= 1'b1;
      best_len  <= rd_route.plen;
      best_gw   <= rd_route.gateway;
      best_port <= rd_route.port;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && (!rsp_valid || rsp_ready)) begin
      found         <= best_hit;
      next_hop      <= best_gw;
      out_port      <= best_port;
      prefix_length <= best_len;
    end
  end

endmodule

// ===== rtl/core/lpm_checker.sv =====
// Port-level checks for the longest prefix match engine, bound to the top level.
module lpm_checker
  import lpm_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               req_valid,
  input logic               req_ready,
  input logic               operation,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic               found,
  input logic [ADDR_W-1:0]  next_hop,
  input logic [PORT_W-1:0]  out_port,
  input logic [LEN_W-1:0]   prefix_length
);

  // a held result beat does not change
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(next_hop)
      && $stable(out_port) && $stable(prefix_length))
    else $error("result beat changed while stalled");

  // a miss reports zeroes
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !found |-> next_hop == '0 && out_port == '0 && prefix_length == '0)
    else $error("miss with non-zero result fields");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> prefix_length <= LEN_W'(ADDR_W))
    else $error("prefix length beyond address width");

  // one beat at a time
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // a route write never gives a result beat
  assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && operation == OP_WRITE && !rsp_valid |=> !rsp_valid)
    else $error("result beat after route write");

endmodule

bind ipv4_longest_prefix_match lpm_checker u_lpm_checker (.*);
